FILE: hw/rtl/llp_pkg.sv
// ----------------------------------------------------------------------------
// llp_pkg
// shared types and constants of the 3x3 local phase pattern core
// ----------------------------------------------------------------------------
package llp_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 11;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_PLANES = 2'd2
  } cfg_reg_e;

  localparam int unsigned WIDTH_REG_BITS  = 11;
  localparam int unsigned HEIGHT_REG_BITS = 11;
  localparam int unsigned PLANE_REG_BITS  = 7;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd128;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 11'd128;
  localparam logic [PLANE_REG_BITS-1:0]  PLANES_RESET = 7'd40;

  // geometry limits
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned MAX_PLANES = 64;

  localparam int unsigned ROW_BITS       = 10;
  localparam int unsigned PLANE_BITS     = 6;
  localparam int unsigned CODE_BITS      = 8;
  localparam int unsigned OUT_TDATA_BITS = 16;

  // geometry registers as seen by the front end
  typedef struct packed {
    logic [WIDTH_REG_BITS-1:0]  width;
    logic [HEIGHT_REG_BITS-1:0] height;
    logic [PLANE_REG_BITS-1:0]  planes;
  } geom_cfg_t;

  // per-pixel tag passed from front to back through the queue
  typedef struct packed {
    logic [PLANE_BITS-1:0] plane;
    logic                  interior;
    logic                  last;
    logic                  quant;
  } pix_tag_t;

  localparam int unsigned TAG_BITS = $bits(pix_tag_t);

endpackage

FILE: hw/rtl/local_phase_pattern_3x3_core.sv
// ----------------------------------------------------------------------------
// local_phase_pattern_3x3_core
// 3x3 local phase pattern codes from a raster stream of filter responses
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one signed response sample per word, planes in raster
//   order back to back. each sample becomes a sign bit (1 when <= 0).
//   m_axis carries one word per interior pixel: the 8-bit xor pattern of
//   the window center against its neighbors (bit7 top-left, clockwise to
//   bit0 left), the plane number, and tlast on the plane's final code.
//   border pixels give no word.
//   the cfg port sets width, height and plane count; write it only while
//   the core is idle.
// timing:
//   one word per clock in and out unless m_axis stalls. samples pass the
//   queue, back stage and output register. two line buffers, each one bit
//   wide and MAX_WIDTH deep, are read and written once per pixel.
// reset and stalls:
//   reset clears positions, window and handshake state; the line buffers
//   are not cleared and need no clearing pass. when m_axis stalls, the
//   output register, the back stage and a two-word queue fill before
//   s_axis_tready drops.
// ----------------------------------------------------------------------------
module local_phase_pattern_3x3_core #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [llp_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [llp_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,  // response_sample
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [llp_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,  // pattern_code, plane_index
  output logic                                  m_axis_tlast   // last_in_plane
);

  localparam int unsigned COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned QUEUE_BITS = COL_BITS + llp_pkg::TAG_BITS;

  // geometry registers
  llp_pkg::geom_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= llp_pkg::WIDTH_RESET;
      cfg_q.height <= llp_pkg::HEIGHT_RESET;
      cfg_q.planes <= llp_pkg::PLANES_RESET;
    end else if (cfg_we_i) begin
      unique case (llp_pkg::cfg_reg_e'(cfg_idx_i))
        llp_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data_i;
        llp_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data_i;
        llp_pkg::CFG_PLANES: cfg_q.planes <= cfg_data_i[llp_pkg::PLANE_REG_BITS-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // front end to queue
  logic                  push_valid, push_ready;
  logic [COL_BITS-1:0]   push_col;
  llp_pkg::pix_tag_t     push_tag;
  // queue to back end
  logic                  pop_valid, pop_ready;
  logic [QUEUE_BITS-1:0] pop_data;
  logic [COL_BITS-1:0]   pop_col;
  llp_pkg::pix_tag_t     pop_tag;
  // back end results
  logic [llp_pkg::CODE_BITS-1:0]  out_code;
  logic [llp_pkg::PLANE_BITS-1:0] out_plane;

  llp_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_BITS    (COL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_col_o   (push_col),
    .push_tag_o   (push_tag)
  );

  llp_fifo #(
    .DATA_BITS (QUEUE_BITS)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_col, push_tag}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_col = pop_data[QUEUE_BITS-1:llp_pkg::TAG_BITS];
  assign pop_tag = pop_data[llp_pkg::TAG_BITS-1:0];

  llp_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_BITS  (COL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_col_i   (pop_col),
    .pop_tag_i   (pop_tag),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (out_code),
    .out_plane_o (out_plane),
    .out_last_o  (m_axis_tlast)
  );

  // code in the low byte, plane above it, zero padding on top
  assign m_axis_tdata = {
    (llp_pkg::OUT_TDATA_BITS - llp_pkg::CODE_BITS - llp_pkg::PLANE_BITS)'(0),
    out_plane, out_code
  };

endmodule

FILE: hw/rtl/llp_front.sv
// ----------------------------------------------------------------------------
// llp_front
// raster position tracking, sign quantization and border classification
// ----------------------------------------------------------------------------
module llp_front #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COL_BITS    = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  llp_pkg::geom_cfg_t       cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output logic [COL_BITS-1:0]      push_col_o,
  output llp_pkg::pix_tag_t        push_tag_o
);

  localparam int unsigned LW = (COL_BITS + 1 > llp_pkg::WIDTH_REG_BITS) ?
                               COL_BITS + 1 : llp_pkg::WIDTH_REG_BITS;
  localparam int unsigned HB = llp_pkg::HEIGHT_REG_BITS;
  localparam int unsigned PB = llp_pkg::PLANE_REG_BITS;

  logic [COL_BITS-1:0]            col_q, col_d;
  logic [llp_pkg::ROW_BITS-1:0]   row_q, row_d;
  logic [llp_pkg::PLANE_BITS-1:0] plane_q, plane_d;
  logic [LW-1:0]                  width_raw, width_eff;
  logic [HB-1:0]                  height_eff;
  logic [PB-1:0]                  planes_eff;
  logic                           last_col, last_row, last_plane, accept;

  // clamp the geometry registers
  always_comb begin
    width_raw = LW'(cfg_i.width);
    if (width_raw < LW'(llp_pkg::MIN_DIM)) begin
      width_eff = LW'(llp_pkg::MIN_DIM);
    end else if (width_raw > LW'(MAX_WIDTH)) begin
      width_eff = LW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    if (cfg_i.height < HB'(llp_pkg::MIN_DIM)) begin
      height_eff = HB'(llp_pkg::MIN_DIM);
    end else if (cfg_i.height > HB'(llp_pkg::MAX_HEIGHT)) begin
      height_eff = HB'(llp_pkg::MAX_HEIGHT);
    end else begin
      height_eff = cfg_i.height;
    end
    if (cfg_i.planes < PB'(1)) begin
      planes_eff = PB'(1);
    end else if (cfg_i.planes > PB'(llp_pkg::MAX_PLANES)) begin
      planes_eff = PB'(llp_pkg::MAX_PLANES);
    end else begin
      planes_eff = cfg_i.planes;
    end
  end

  assign last_col   = (LW'(col_q) + LW'(1)) >= width_eff;
  assign last_row   = (HB'(row_q) + HB'(1)) >= height_eff;
  assign last_plane = (PB'(plane_q) + PB'(1)) >= planes_eff;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign push_col_o          = col_q;
  assign push_tag_o.plane    = plane_q;
  assign push_tag_o.interior = (col_q >= COL_BITS'(2)) && (row_q >= llp_pkg::ROW_BITS'(2));
  assign push_tag_o.last     = last_col && last_row;
  // 1 when the response is zero or negative
  assign push_tag_o.quant    = sample_i[SAMPLE_BITS-1] || (sample_i == '0);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    plane_d = plane_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d   = '0;
          plane_d = last_plane ? '0 : plane_q + 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

endmodule

FILE: hw/rtl/llp_fifo.sv
// ----------------------------------------------------------------------------
// llp_fifo
// two-entry queue between the front and back ends
// ----------------------------------------------------------------------------
module llp_fifo #(
  parameter int unsigned DATA_BITS = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  logic [DATA_BITS-1:0] push_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output logic [DATA_BITS-1:0] pop_data_o
);

  logic [DATA_BITS-1:0] mem_q [2];
  logic                 wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]           count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/llp_back.sv
// ----------------------------------------------------------------------------
// llp_back
// line buffers, 3x3 bit window, pattern code and output register
// ----------------------------------------------------------------------------
module llp_back #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned COL_BITS  = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pop_valid_i,
  output logic                             pop_ready_o,
  input  logic [COL_BITS-1:0]              pop_col_i,
  input  llp_pkg::pix_tag_t                pop_tag_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [llp_pkg::CODE_BITS-1:0]    out_code_o,
  output logic [llp_pkg::PLANE_BITS-1:0]   out_plane_o,
  output logic                             out_last_o
);

  // line buffers of sign bits, no reset
  logic mem_above_q     [MAX_WIDTH];
  logic mem_two_above_q [MAX_WIDTH];

  logic                  s1_valid_q, s1_valid_d;
  logic [COL_BITS-1:0]   s1_col_q;
  llp_pkg::pix_tag_t     s1_tag_q;
  logic                  rd_above_q, rd_two_above_q;
  logic [2:0]            win_c0_q, win_c1_q;   // column c-2 and c-1, bit0 = two above
  logic                  out_valid_q, out_valid_d;
  logic [llp_pkg::CODE_BITS-1:0]  code_q, code_d;
  logic [llp_pkg::PLANE_BITS-1:0] plane_q;
  logic                  last_q;
  logic                  out_free, s1_adv, pop, mm;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && (!s1_tag_q.interior || out_free);
  assign pop_ready_o = !s1_valid_q || s1_adv;
  assign pop         = pop_valid_i && pop_ready_o;

  // center bit against the eight neighbors, clockwise from top-left
  always_comb begin
    mm     = win_c1_q[1];
    code_d = {mm ^ win_c0_q[0], mm ^ win_c1_q[0], mm ^ rd_two_above_q, mm ^ rd_above_q,
              mm ^ s1_tag_q.quant, mm ^ win_c1_q[2], mm ^ win_c0_q[2], mm ^ win_c0_q[1]};
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_tag_q.interior) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      win_c0_q    <= '0;
      win_c1_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        win_c0_q <= win_c1_q;
        win_c1_q <= {s1_tag_q.quant, rd_above_q, rd_two_above_q};
      end
    end
  end

  // line buffer read on pop, write back when the pixel leaves the stage
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_col_q       <= pop_col_i;
      s1_tag_q       <= pop_tag_i;
      rd_above_q     <= mem_above_q[pop_col_i];
      rd_two_above_q <= mem_two_above_q[pop_col_i];
    end
    if (s1_adv) begin
      mem_above_q[s1_col_q]     <= s1_tag_q.quant;
      mem_two_above_q[s1_col_q] <= rd_above_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_tag_q.interior) begin
      code_q  <= code_d;
      plane_q <= s1_tag_q.plane;
      last_q  <= s1_tag_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = code_q;
  assign out_plane_o = plane_q;
  assign out_last_o  = last_q;

endmodule

FILE: hw/rtl/llp_checker.sv
// ----------------------------------------------------------------------------
// llp_checker
// port-level checks of the local phase pattern core
// ----------------------------------------------------------------------------
module llp_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [llp_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic                               m_axis_tlast
);

  localparam int unsigned PAD_LSB = llp_pkg::CODE_BITS + llp_pkg::PLANE_BITS;

  // a stalled word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // padding bits above the plane number are always zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[llp_pkg::OUT_TDATA_BITS-1:PAD_LSB] == '0)
    else $error("nonzero padding in output word");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid straight after reset");

  // a rising valid needs reset to have been released earlier, so an input had time to pass
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(rst_ni, 2))
    else $error("output valid without time for an input to pass");

endmodule

bind local_phase_pattern_3x3_core llp_checker u_llp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 3x3 local phase pattern core
// ----------------------------------------------------------------------------
// response samples go in on s_axis. a bit-level predictor keeps its own
// line buffers, window, positions and geometry registers, and queues one
// expected word per interior pixel. a monitor pops that queue on every
// accepted m_axis word and compares code, plane, padding and tlast.
// directed tests cover the default geometry, sample extremes, clamped
// geometry, plane count wrap, an unused register index and live writes;
// random planes follow under three idle profiles on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  import llp_pkg::*;

  localparam int unsigned LINE_DEPTH    = 1024;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // extra settling time once no codes are owed
  localparam int unsigned SETTLE_CYCLES = 8;
  // index that maps to no register, writes to it must be dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

  // one expected output word
  typedef struct packed {
    logic [CODE_BITS-1:0]  code;
    logic [PLANE_BITS-1:0] plane;
    logic                  last;
  } pattern_word_t;

  // dut ports; every input the bench drives is known from time zero
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [SAMPLE_W-1:0]      s_axis_tdata  = '0;  // response_sample
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;       // pattern_code, plane_index
  logic                     m_axis_tlast;        // last_in_plane

  // idle profile, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // bookkeeping
  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned samples_sent  = 0;
  int unsigned words_checked = 0;
  int unsigned planes_seen   = 0;

  // predictor state: geometry registers as written
  logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_BITS-1:0] height_reg = HEIGHT_RESET;
  logic [PLANE_REG_BITS-1:0]  planes_reg = PLANES_RESET;

  // predictor state: sign bits of the two rows above, 3x2 window, positions
  logic                  line_above     [LINE_DEPTH];
  logic                  line_two_above [LINE_DEPTH];
  logic [5:0]            win_bits  = '0;  // [2:0] column c-2, [5:3] column c-1
  logic [9:0]            col_pos   = '0;
  logic [ROW_BITS-1:0]   row_pos   = '0;
  logic [PLANE_BITS-1:0] plane_pos = '0;

  // codes still owed by the dut, oldest first
  pattern_word_t pattern_queue[$];

  local_phase_pattern_3x3_core #(
    .MAX_WIDTH  (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codes still owed", cycle_count,
               pattern_queue.size());
      $display("local_phase_pattern_3x3_core test failed");
      $finish;
    end
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned active_width();
    return clamp_dim(32'(width_reg), MIN_DIM, LINE_DEPTH);
  endfunction

  function automatic int unsigned active_height();
    return clamp_dim(32'(height_reg), MIN_DIM, MAX_HEIGHT);
  endfunction

  function automatic int unsigned active_planes();
    return clamp_dim(32'(planes_reg), 1, MAX_PLANES);
  endfunction

  // register file as the predictor sees it; unknown index is dropped
  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      CFG_WIDTH:  width_reg  = val[WIDTH_REG_BITS-1:0];
      CFG_HEIGHT: height_reg = val[HEIGHT_REG_BITS-1:0];
      CFG_PLANES: planes_reg = val[PLANE_REG_BITS-1:0];
      default: ;
    endcase
  endfunction

  // advance the pixel pipeline by one sample, queue a code for interior pixels
  function automatic void predict_pattern(logic [SAMPLE_W-1:0] sample);
    int unsigned   w;
    int unsigned   h;
    int unsigned   np;
    logic          q;
    logic          t1;
    logic          t2;
    logic          mm;
    logic [2:0]    cur_col;
    logic          last_col;
    logic          last_row;
    pattern_word_t word;
    w  = active_width();
    h  = active_height();
    np = active_planes();
    // sign bit: set for negative values and for zero
    q  = sample[SAMPLE_W-1] | (sample == '0);
    t2 = line_two_above[col_pos];
    t1 = line_above[col_pos];
    cur_col  = {q, t1, t2};
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    if (col_pos >= 2 && row_pos >= 2) begin
      mm = win_bits[4];
      word.code  = {mm ^ win_bits[0], mm ^ win_bits[3], mm ^ t2, mm ^ t1,
                    mm ^ q, mm ^ win_bits[5], mm ^ win_bits[2], mm ^ win_bits[1]};
      word.plane = plane_pos;
      word.last  = last_col & last_row;
      pattern_queue.insert(pattern_queue.size(), word);
    end
    line_two_above[col_pos] = t1;
    line_above[col_pos]     = q;
    win_bits = {cur_col, win_bits[5:3]};
    if (last_col) begin
      col_pos = '0;
      if (last_row) begin
        row_pos = '0;
        planes_seen++;
        if (plane_pos + 1 >= np) plane_pos = '0;
        else plane_pos = plane_pos + 1'b1;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  // random full-range values in three of eight picks, sign boundary values otherwise
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3:       return 16'hffff;
      4:       return 16'h0001;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // output monitor: every accepted word against the oldest expected code
  always @(posedge clk_i) begin : check_word
    pattern_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pattern_queue.size() == 0) begin
        $error("unexpected word: tdata %04h tlast %0b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = pattern_queue.pop_front();
        words_checked++;
        if (m_axis_tdata[CODE_BITS-1:0] !== want.code) begin
          $error("pattern_code mismatch: expected %02h, got %02h", want.code,
                 m_axis_tdata[CODE_BITS-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[CODE_BITS +: PLANE_BITS] !== want.plane) begin
          $error("plane_index mismatch: expected %0d, got %0d", want.plane,
                 m_axis_tdata[CODE_BITS +: PLANE_BITS]);
          fail_count++;
        end
        if (m_axis_tdata[OUT_TDATA_BITS-1:CODE_BITS+PLANE_BITS] !== '0) begin
          $error("tdata padding mismatch: expected 0, got %0h",
                 m_axis_tdata[OUT_TDATA_BITS-1:CODE_BITS+PLANE_BITS]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_in_plane mismatch: expected %0b, got %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // hold the input off until every owed code is out and the pipe has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pattern_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write, only ever done with the core idle
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned np);
    write_reg(CFG_WIDTH, CFG_DATA_BITS'(w));
    write_reg(CFG_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(CFG_PLANES, CFG_DATA_BITS'(np));
  endtask

  // one word on s_axis; valid stays high into the next call unless it idles
  task automatic send_sample(logic [SAMPLE_W-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pattern(sample);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // random samples up to the start of the next plane
  task automatic finish_plane();
    while (col_pos != 0 || row_pos != 0) send_sample(pick_sample());
  endtask

  task automatic send_planes(int unsigned n);
    repeat (n * active_width() * active_height()) send_sample(pick_sample());
  endtask

  // reset width of 128 closes row 0, then width and height cut in row 1
  task automatic test_reset_geometry();
    repeat (128 + 5) send_sample(pick_sample());
    // column 5 is beyond the new width, so this row closes at once
    write_reg(CFG_WIDTH, CFG_DATA_BITS'(3));
    write_reg(CFG_HEIGHT, CFG_DATA_BITS'(3));
    write_reg(CFG_PLANES, CFG_DATA_BITS'(1));
    finish_plane();
  endtask

  // sign extremes on 3x3 planes: all-different, all-equal and cross patterns
  task automatic test_sample_extremes();
    logic [SAMPLE_W-1:0] edge_val;
    logic [SAMPLE_W-1:0] center_val;
    set_geometry(3, 3, 4);
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 9; i++) begin
        case (p)
          0: begin edge_val = 16'h7fff; center_val = 16'h0000; end
          1: begin edge_val = 16'h8000; center_val = 16'h0001; end
          2: begin edge_val = 16'hffff; center_val = 16'h8000; end
          default: begin
            edge_val   = (i % 2) ? 16'h0000 : 16'h7fff;
            center_val = 16'h7fff;
          end
        endcase
        send_sample((i == 4) ? center_val : edge_val);
      end
    end
  endtask

  // out-of-range geometry: width, height and plane count below their floors
  task automatic test_geometry_clamp();
    set_geometry(0, 2, 0);
    send_planes(2);
  endtask

  // plane counter wrap back to plane 0
  task automatic test_plane_count();
    set_geometry(3, 3, 2);
    send_planes(3);
  endtask

  // write to an index with no register behind it must change nothing
  task automatic test_unused_index();
    set_geometry(4, 3, 1);
    write_reg(CFG_UNUSED, 11'h005);
    send_planes(1);
  endtask

  // width shrunk while the column is already past the new edge
  task automatic test_live_width_cut();
    set_geometry(8, 5, 1);
    repeat (2 * 8 + 5) send_sample(pick_sample());
    write_reg(CFG_WIDTH, CFG_DATA_BITS'(4));
    finish_plane();
    send_planes(1);
  endtask

  // random whole planes of random small geometry
  task automatic test_random_stream(int unsigned target, int unsigned s_pct,
                                    int unsigned r_pct);
    int unsigned start;
    int unsigned w;
    start = samples_sent;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (samples_sent - start < target) begin
      w = $urandom_range(3, 10);
      set_geometry(w, $urandom_range(3, 6), $urandom_range(1, 2));
      send_planes(active_planes());
    end
  endtask

  initial begin
    send_idle_pct = 12;
    recv_idle_pct = 56;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_geometry();
    test_sample_extremes();
    test_geometry_clamp();
    test_plane_count();
    test_unused_index();
    test_live_width_cut();
    test_random_stream(40, 12, 56);
    test_random_stream(40, 56, 12);
    test_random_stream(40, 0, 0);

    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);
    if (pattern_queue.size() != 0) begin
      $error("%0d expected codes never arrived", pattern_queue.size());
      fail_count++;
    end

    $display("sent %0d samples over %0d planes, checked %0d codes in %0d cycles",
             samples_sent, planes_seen, words_checked, cycle_count);
    $display("covered reset and clamped geometry, live writes, plane wrap, unused index,"
             , " three idle mixes");
    if (fail_count == 0) begin
      $display("local_phase_pattern_3x3_core test passed");
    end else begin
      $display("local_phase_pattern_3x3_core test failed");
    end
    $finish;
  end

endmodule
